>>> design/base64_stream_encoder_defines.svh
// assertion macros for the base64 stream encoder checker
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define B64E_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define B64E_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/b64e_pkg.sv
// shared types, constants and the sextet-to-character function of the base64 encoder
package b64e_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [6:0] PAD_CHAR      = 7'd61;
   localparam logic [1:0] CHAR_IDX_LAST = 2'd3;
   localparam logic [2:0] CHARS_PER_GROUP = 3'd4;

   // one complete or flushed group of up to three bytes
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  pad_count;
      logic        fin;
   } group_type;

   // front to queue
   typedef struct packed {
      logic      valid;
      group_type group;
   } push_type;

   // queue head to back
   typedef struct packed {
      logic      valid;
      group_type group;
   } head_type;

   // standard alphabet lookup
   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] code;
      code = 7'(v);
      if (v < 6'd26) begin
         sextet_char = code + 7'd65;
      end else if (v < 6'd52) begin
         sextet_char = code + 7'd71;
      end else if (v < 6'd62) begin
         sextet_char = code - 7'd4;
      end else if (v == 6'd62) begin
         sextet_char = 7'd43;
      end else begin
         sextet_char = 7'd47;
      end
   endfunction

endpackage

>>> design/b64e_stream_if.sv
// valid/ready channel interfaces for raw bytes in and characters out
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       run_last;
   logic       message_end;

   modport source (output valid, output out_char, output run_last, output message_end,
                   input ready);
   modport sink   (input valid, input out_char, input run_last, input message_end,
                   output ready);
endinterface

>>> design/base64_stream_encoder.sv
// Base64 stream encoder top level: collector, group queue, character serializer.
// A closing beat enters the queue, then the serializer's group register, then the output
// register; a group's four characters follow on consecutive cycles while rsp is ready.
// Throughput: one byte per cycle while the two-entry queue has room; sustained rate is set
// by the serializer's single output register at one character per cycle (4 per 3 bytes).
// Reset is synchronous, active high: held count, queue and output valid clear.
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_chan,
   b64e_rsp_if.source rsp_chan
);

   b64e_pkg::push_type push;
   b64e_pkg::head_type head;
   logic               queue_full;
   logic               pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push)
   );

   b64e_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (pop),
      .head  (head)
   );

   b64e_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> design/b64e_queue.sv
// short group queue between the byte collector and the character serializer
module b64e_queue (
   input  logic                clock,
   input  logic                reset,
   input  b64e_pkg::push_type  push,
   output logic                full,
   input  logic                pop,
   output b64e_pkg::head_type  head
);

   b64e_pkg::group_type                  mem_ff [b64e_pkg::QUEUE_DEPTH];
   logic [b64e_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [b64e_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [b64e_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                                 push_ok;
   logic                                 pop_ok;

   localparam logic [b64e_pkg::QUEUE_PTR_W-1:0] PtrLast =
      b64e_pkg::QUEUE_PTR_W'(b64e_pkg::QUEUE_DEPTH - 1);
   localparam logic [b64e_pkg::QUEUE_CNT_W-1:0] CntFull =
      b64e_pkg::QUEUE_CNT_W'(b64e_pkg::QUEUE_DEPTH);

   assign full       = (count_ff == CntFull);
   assign push_ok    = push.valid && !full;
   assign pop_ok     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.group = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push.group;
      end
   end

endmodule

>>> design/b64e_front.sv
// byte collector: holds pending bytes and forms groups on the third or final byte
module b64e_front (
   input  logic               clock,
   input  logic               reset,
   b64e_req_if.sink           req_chan,
   input  logic               queue_full,
   output b64e_pkg::push_type push
);

   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] count_ff, count_in;
   logic       accept;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   // classify the beat: hold it or close the group
   always_comb begin
      held0_in        = held0_ff;
      held1_in        = held1_ff;
      count_in        = count_ff;
      push.valid      = 1'b0;
      push.group.bits = {held0_ff, held1_ff, req_chan.data_byte};
      push.group.pad_count = 2'd0;
      push.group.fin  = req_chan.final_byte;
      unique case (count_ff)
         2'd0: begin
            push.group.bits      = {req_chan.data_byte, 16'd0};
            push.group.pad_count = 2'd2;
            if (accept) begin
               if (req_chan.final_byte) begin
                  push.valid = 1'b1;
               end else begin
                  held0_in = req_chan.data_byte;
                  count_in = 2'd1;
               end
            end
         end
         2'd1: begin
            push.group.bits      = {held0_ff, req_chan.data_byte, 8'd0};
            push.group.pad_count = 2'd1;
            if (accept) begin
               if (req_chan.final_byte) begin
                  push.valid = 1'b1;
                  count_in   = 2'd0;
               end else begin
                  held1_in = req_chan.data_byte;
                  count_in = 2'd2;
               end
            end
         end
         default: begin
            if (accept) begin
               push.valid = 1'b1;
               count_in   = 2'd0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

endmodule

>>> design/b64e_back.sv
// character serializer: turns each queued group into four output beats
module b64e_back (
   input  logic               clock,
   input  logic               reset,
   input  b64e_pkg::head_type head,
   output logic               pop,
   b64e_rsp_if.source         rsp_chan
);

   b64e_pkg::group_type group_ff, group_in;
   logic                busy_ff, busy_in;
   logic [1:0]          idx_ff, idx_in;
   logic                out_valid_ff, out_valid_in;
   logic [6:0]          out_char_ff, out_char_in;
   logic                run_last_ff, run_last_in;
   logic                message_end_ff, message_end_in;
   logic                can_load;
   logic                emit;
   logic                last_char;
   logic [5:0]          sextet;
   logic [2:0]          pos_sum;

   assign can_load  = !out_valid_ff || rsp_chan.ready;
   assign emit      = busy_ff && can_load;
   assign last_char = (idx_ff == b64e_pkg::CHAR_IDX_LAST);
   assign pop       = head.valid && (!busy_ff || (emit && last_char));

   // sextet for the current character position
   always_comb begin
      unique case (idx_ff)
         2'd0:    sextet = group_ff.bits[23:18];
         2'd1:    sextet = group_ff.bits[17:12];
         2'd2:    sextet = group_ff.bits[11:6];
         default: sextet = group_ff.bits[5:0];
      endcase
   end

   // padding covers the trailing pad_count positions
   assign pos_sum = {1'b0, idx_ff} + {1'b0, group_ff.pad_count};

   // sequencing and output register
   always_comb begin
      group_in       = group_ff;
      busy_in        = busy_ff;
      idx_in         = idx_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_char_in    = out_char_ff;
      run_last_in    = run_last_ff;
      message_end_in = message_end_ff;
      if (emit) begin
         out_valid_in   = 1'b1;
         out_char_in    = (pos_sum >= b64e_pkg::CHARS_PER_GROUP) ? b64e_pkg::PAD_CHAR
                                                                 : b64e_pkg::sextet_char(sextet);
         run_last_in    = last_char;
         message_end_in = last_char && group_ff.fin;
         idx_in         = idx_ff + 2'd1;
         if (last_char) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         group_in = head.group;
         busy_in  = 1'b1;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      group_ff       <= group_in;
      out_char_ff    <= out_char_in;
      run_last_ff    <= run_last_in;
      message_end_ff <= message_end_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.out_char    = out_char_ff;
   assign rsp_chan.run_last    = run_last_ff;
   assign rsp_chan.message_end = message_end_ff;

endmodule

>>> design/b64e_checker.sv
// port-level checker for the base64 stream encoder and its bind
`include "base64_stream_encoder_defines.svh"

module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] out_char,
   input logic       run_last,
   input logic       message_end
);

   logic legal_char;

   // alphabet letters, digits, plus, slash or padding
   assign legal_char = ((out_char >= 7'd65) && (out_char <= 7'd90)) ||
                       ((out_char >= 7'd97) && (out_char <= 7'd122)) ||
                       ((out_char >= 7'd48) && (out_char <= 7'd57)) ||
                       (out_char == 7'd43) || (out_char == 7'd47) || (out_char == 7'd61);

   `B64E_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid, "rsp valid after reset")
   `B64E_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_char) && $stable(run_last) && $stable(message_end), "stalled rsp beat changed")
   `B64E_ASSERT_NOW(a_end_is_run_last, clock, reset, rsp_valid && message_end, run_last, "message end without run last")
   `B64E_ASSERT_NOW(a_legal_char, clock, reset, rsp_valid, legal_char, "character outside base64 alphabet")
   `B64E_ASSERT_NOW(a_req_ready_known, clock, reset, req_valid, !$isunknown(req_ready), "req ready unknown")

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_char    (rsp_chan.out_char),
   .run_last    (rsp_chan.run_last),
   .message_end (rsp_chan.message_end)
);
